### rtl/bfps_pkg.sv
// Package for the bit field pack/unpack store.
// Holds request codes, the queued request type and the bit mask helper.
// No dependencies.
`default_nettype none

package bfps_pkg;

  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned POS_W     = 17;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_SEEK  = 2'd2;

  typedef struct packed {
    logic [1:0]           kind;
    logic [CNT_W-1:0]     n;
    logic [WORD_BITS-1:0] value;
    logic [POS_W-1:0]     target;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [WORD_BITS-1:0] low_mask(input logic [CNT_W-1:0] n);
    logic [WORD_BITS-1:0] m;
    if (n >= CNT_W'(WORD_BITS)) begin
      m = '1;
    end else begin
      m = (WORD_BITS'(1) << n) - WORD_BITS'(1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

### rtl/bfps_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module bfps_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/bfps_front.sv
// Front end: takes requests, clamps the bit count, masks the write value.
// Depends on bfps_pkg.
`default_nettype none

module bfps_front (
  input  logic                                  start,
  input  logic [1:0]                            req_type,
  input  logic [bfps_pkg::CNT_W-1:0]            bit_count,
  input  logic [bfps_pkg::WORD_BITS-1:0]        write_value,
  input  logic [bfps_pkg::POS_W-1:0]            seek_target,
  input  bfps_pkg::q_status_t                   q_status,
  input  logic                                  clearing,
  output logic                                  busy,
  output logic                                  push,
  output bfps_pkg::req_t                        req
);

  logic [bfps_pkg::CNT_W-1:0] n_clamped;

  assign n_clamped = (bit_count > bfps_pkg::CNT_W'(bfps_pkg::WORD_BITS)) ?
                     bfps_pkg::CNT_W'(bfps_pkg::WORD_BITS) : bit_count;

  assign busy = q_status.full | clearing;
  assign push = start & ~busy;

  always_comb begin
    req.kind   = req_type;
    req.n      = n_clamped;
    req.value  = write_value & bfps_pkg::low_mask(n_clamped);
    req.target = seek_target;
  end

endmodule

`default_nettype wire

### rtl/bfps_queue.sv
// Two-entry request queue between front and back end.
// Depends on bfps_pkg.
`default_nettype none

module bfps_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bfps_pkg::req_t      req,
  input  logic                pop,
  output bfps_pkg::req_t      head,
  output bfps_pkg::q_status_t status
);

  bfps_pkg::req_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= req;
    end
  end

  assign head         = slot[rd_ptr];
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

endmodule

`default_nettype wire

### rtl/bfps_back.sv
// Back end: cursor, length and error state, word store in even/odd banks.
// Depends on bfps_pkg and bfps_ram.
`default_nettype none

module bfps_back #(
  parameter int unsigned STORE_WORDS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bfps_pkg::req_t                  head,
  input  logic                            empty,
  output logic                            pop,
  output logic                            clearing,
  output logic                            done,
  output logic [bfps_pkg::WORD_BITS-1:0]  read_value,
  output logic                            error_flag,
  output logic [bfps_pkg::POS_W-1:0]      bit_position
);

  localparam int unsigned CAP  = STORE_WORDS * bfps_pkg::WORD_BITS;
  localparam int unsigned CW   = $clog2(CAP + 1);
  localparam int unsigned HALF = (STORE_WORDS + 1) / 2;
  localparam int unsigned BD   = (HALF < 2) ? 2 : HALF;
  localparam int unsigned AW   = $clog2(BD);
  localparam int unsigned PW   = (CW > bfps_pkg::POS_W) ? CW : bfps_pkg::POS_W;
  localparam int unsigned WB   = bfps_pkg::WORD_BITS;
  localparam int unsigned NW   = bfps_pkg::CNT_W;

  typedef enum logic [1:0] {CLEAR, IDLE, EXEC} state_t;

  state_t         state;
  logic [AW-1:0]  clr_addr;
  bfps_pkg::req_t cur;
  logic [CW-1:0]  cursor;
  logic [CW-1:0]  length;
  logic           err;

  logic [CW-1:0]  cursor_next;
  logic [CW-1:0]  length_next;
  logic           err_next;
  logic [WB-1:0]  result;
  logic           exec;

  logic [CW:0]    end_pos;
  logic           overrun;
  logic [5:0]     off;
  logic [NW-1:0]  off_ext;
  logic [NW-1:0]  sh_hi;
  logic           odd;
  logic           straddle;
  logic [WB-1:0]  lo;
  logic [WB-1:0]  hi;
  logic [WB-1:0]  lo_new;
  logic [WB-1:0]  hi_new;
  logic [WB-1:0]  rd_bits;
  logic           we_lo;
  logic           we_hi;
  logic [PW-1:0]  target_ext;
  logic [PW-1:0]  length_ext;
  logic [PW-1:0]  pos_ext;

  logic [CW-1:0]  rd_cursor;
  logic [CW-7:0]  w_odd_idx;
  logic [CW-7:0]  w_even_idx;
  logic [CW-7:0]  r_odd_idx;
  logic [CW-7:0]  r_even_idx;

  logic           even_we;
  logic           odd_we;
  logic [AW-1:0]  even_wa;
  logic [AW-1:0]  odd_wa;
  logic [AW-1:0]  even_ra;
  logic [AW-1:0]  odd_ra;
  logic [WB-1:0]  even_wd;
  logic [WB-1:0]  odd_wd;
  logic [WB-1:0]  even_q;
  logic [WB-1:0]  odd_q;
  logic [WB-1:0]  even_d;
  logic [WB-1:0]  odd_d;
  logic           fwd_even;
  logic           fwd_odd;
  logic [WB-1:0]  fwd_even_d;
  logic [WB-1:0]  fwd_odd_d;

  assign exec     = (state == EXEC);
  assign clearing = (state == CLEAR);
  assign pop      = ~empty & ((state == IDLE) | exec);

  assign end_pos  = {1'b0, cursor} + (CW + 1)'(cur.n);
  assign overrun  = end_pos > (CW + 1)'(CAP);
  assign off      = cursor[5:0];
  assign odd      = cursor[6];
  assign off_ext  = {1'b0, off};
  assign sh_hi    = NW'(WB) - off_ext;
  assign straddle = (off_ext + cur.n) > NW'(WB);

  assign even_d = fwd_even ? fwd_even_d : even_q;
  assign odd_d  = fwd_odd ? fwd_odd_d : odd_q;
  assign lo     = odd ? odd_d : even_d;
  assign hi     = odd ? even_d : odd_d;
  assign lo_new = lo | (cur.value << off);
  assign hi_new = hi | (cur.value >> sh_hi);
  assign rd_bits = ((lo >> off) | (hi << sh_hi)) & bfps_pkg::low_mask(cur.n);

  assign target_ext = PW'(cur.target);
  assign length_ext = PW'(length);

  always_comb begin
    cursor_next = cursor;
    length_next = length;
    err_next    = err;
    result      = '0;
    we_lo       = 1'b0;
    we_hi       = 1'b0;
    if (exec) begin
      case (cur.kind)
        bfps_pkg::REQ_WRITE, bfps_pkg::REQ_READ: begin
          if (overrun) begin
            err_next = 1'b1;
          end else if (cur.n != '0) begin
            cursor_next = end_pos[CW-1:0];
            if (cur.kind == bfps_pkg::REQ_WRITE) begin
              we_lo = 1'b1;
              we_hi = straddle;
              if (end_pos[CW-1:0] > length) begin
                length_next = end_pos[CW-1:0];
              end
            end else begin
              result = rd_bits;
            end
          end
        end
        bfps_pkg::REQ_SEEK: begin
          cursor_next = (target_ext < length_ext) ? target_ext[CW-1:0] : length;
        end
        default: begin
        end
      endcase
    end
  end

  assign pos_ext = PW'(cursor_next);

  assign w_odd_idx  = {1'b0, cursor[CW-1:7]};
  assign w_even_idx = w_odd_idx + (CW - 6)'(odd);
  assign rd_cursor  = exec ? cursor_next : cursor;
  assign r_odd_idx  = {1'b0, rd_cursor[CW-1:7]};
  assign r_even_idx = r_odd_idx + (CW - 6)'(rd_cursor[6]);

  assign even_we = clearing | (we_lo & ~odd) | (we_hi & odd);
  assign odd_we  = clearing | (we_lo & odd) | (we_hi & ~odd);
  assign even_wa = clearing ? clr_addr : w_even_idx[AW-1:0];
  assign odd_wa  = clearing ? clr_addr : w_odd_idx[AW-1:0];
  assign even_wd = clearing ? '0 : (odd ? hi_new : lo_new);
  assign odd_wd  = clearing ? '0 : (odd ? lo_new : hi_new);
  assign even_ra = r_even_idx[AW-1:0];
  assign odd_ra  = r_odd_idx[AW-1:0];

  bfps_ram #(.WIDTH(WB), .DEPTH(BD), .AW(AW)) u_even_ram (
    .clk   (clk),
    .we    (even_we),
    .waddr (even_wa),
    .wdata (even_wd),
    .raddr (even_ra),
    .rdata (even_q)
  );

  bfps_ram #(.WIDTH(WB), .DEPTH(BD), .AW(AW)) u_odd_ram (
    .clk   (clk),
    .we    (odd_we),
    .waddr (odd_wa),
    .wdata (odd_wd),
    .raddr (odd_ra),
    .rdata (odd_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= CLEAR;
      clr_addr     <= '0;
      cursor       <= '0;
      length       <= '0;
      err          <= 1'b0;
      fwd_even     <= 1'b0;
      fwd_odd      <= 1'b0;
      done         <= 1'b0;
      read_value   <= '0;
      error_flag   <= 1'b0;
      bit_position <= '0;
    end else begin
      done     <= exec;
      cursor   <= cursor_next;
      length   <= length_next;
      err      <= err_next;
      fwd_even <= even_we & (even_wa == even_ra);
      fwd_odd  <= odd_we & (odd_wa == odd_ra);
      if (exec) begin
        read_value   <= result;
        error_flag   <= err_next;
        bit_position <= pos_ext[bfps_pkg::POS_W-1:0];
      end
      case (state)
        CLEAR: begin
          if (clr_addr == AW'(BD - 1)) begin
            state <= IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        IDLE: begin
          if (pop) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          if (!pop) begin
            state <= IDLE;
          end
        end
        default: state <= CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    fwd_even_d <= even_wd;
    fwd_odd_d  <= odd_wd;
    if (pop) begin
      cur <= head;
    end
  end

endmodule

`default_nettype wire

### rtl/bit_field_pack_unpack_store.sv
// Bit field pack/unpack store, top level: front end, request queue, back end.
// Depends on bfps_pkg, bfps_front, bfps_queue, bfps_back.
//
// A request is taken at a clock edge with start high and busy low. Each request
// gives one result: done is high for one cycle with read_value, error_flag and
// bit_position, which hold until the next result. A taken request waits in the
// queue slot while the store is read, then its result goes into the result
// register, and requests are taken and answered at up to one per cycle while
// busy is low: the store is split into even and odd word banks, so both words
// of a field straddling two words are read and written at once, with
// write-to-read forwarding between requests. The receiver cannot stall;
// results leave as they finish. After reset the block clears the store and
// holds busy high while it does so.
`default_nettype none

module bit_field_pack_unpack_store #(
  parameter int unsigned STORE_WORDS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      req_type,
  input  logic [bfps_pkg::CNT_W-1:0]      bit_count,
  input  logic [bfps_pkg::WORD_BITS-1:0]  write_value,
  input  logic [bfps_pkg::POS_W-1:0]      seek_target,
  output logic                            done,
  output logic [bfps_pkg::WORD_BITS-1:0]  read_value,
  output logic                            error_flag,
  output logic [bfps_pkg::POS_W-1:0]      bit_position
);

  bfps_pkg::q_status_t q_status;
  bfps_pkg::req_t      req;
  bfps_pkg::req_t      head;
  logic                push;
  logic                pop;
  logic                clearing;

  bfps_front u_front (
    .start       (start),
    .req_type    (req_type),
    .bit_count   (bit_count),
    .write_value (write_value),
    .seek_target (seek_target),
    .q_status    (q_status),
    .clearing    (clearing),
    .busy        (busy),
    .push        (push),
    .req         (req)
  );

  bfps_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .req    (req),
    .pop    (pop),
    .head   (head),
    .status (q_status)
  );

  bfps_back #(.STORE_WORDS(STORE_WORDS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (q_status.empty),
    .pop          (pop),
    .clearing     (clearing),
    .done         (done),
    .read_value   (read_value),
    .error_flag   (error_flag),
    .bit_position (bit_position)
  );

endmodule

`default_nettype wire

### rtl/bfps_checker.sv
// Port-level checker for the bit field pack/unpack store, bound to the top.
// Depends on bit_field_pack_unpack_store.
`default_nettype none

module bfps_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic [63:0] read_value,
  input logic        error_flag,
  input logic [16:0] bit_position
);

  a_clear_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_flag |=> error_flag)
    else $error("error flag dropped");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && error_flag && !$past(error_flag)) |-> (read_value == 64'd0))
    else $error("failing request returned data");

  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    !done |-> $stable(bit_position))
    else $error("bit position moved without a result");

endmodule

bind bit_field_pack_unpack_store bfps_checker u_checker (.*);

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for bit_field_pack_unpack_store: directed table, then random traffic.
// Each result is checked against an in-bench model of the bit store, or against the table answer for typed rows.
// Depends on bfps_pkg and the bit_field_pack_unpack_store RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned WORD_BITS   = bfps_pkg::WORD_BITS;
  localparam int unsigned CNT_W       = bfps_pkg::CNT_W;
  localparam int unsigned POS_W       = bfps_pkg::POS_W;
  localparam logic [1:0]  REQ_WRITE   = bfps_pkg::REQ_WRITE;
  localparam logic [1:0]  REQ_READ    = bfps_pkg::REQ_READ;
  localparam logic [1:0]  REQ_SEEK    = bfps_pkg::REQ_SEEK;

  typedef bfps_pkg::req_t req_t;

  localparam int unsigned STORE_WORDS = 1024;
  localparam int unsigned CAPACITY    = STORE_WORDS * WORD_BITS;
  localparam logic [1:0]  REQ_NONE    = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 590;
  localparam int unsigned POS_MAX     = (1 << POS_W) - 1;

  typedef struct packed {
    logic [WORD_BITS-1:0] rd;
    logic                 err;
    logic [POS_W-1:0]     pos;
  } answer_t;

  typedef struct packed {
    req_t    req;
    logic    typed;
    answer_t ans;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           req_type = '0;
  logic [CNT_W-1:0]     bit_count = '0;
  logic [WORD_BITS-1:0] write_value = '0;
  logic [POS_W-1:0]     seek_target = '0;
  logic                 done;
  logic [WORD_BITS-1:0] read_value;
  logic                 error_flag;
  logic [POS_W-1:0]     bit_position;

  logic [WORD_BITS-1:0] model_store [0:STORE_WORDS-1];
  int unsigned          model_cursor;
  int unsigned          model_length;
  logic                 model_error;

  answer_t  awaited [$];
  answer_t  head;
  dir_row_t directed_rows [$];

  int failures;
  int items_sent;
  int results_checked;
  int n_writes, n_reads, n_seeks, n_unused, n_overruns;
  bit idle_enabled;
  bit tail_phase;

  bit_field_pack_unpack_store #(.STORE_WORDS(STORE_WORDS)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .bit_count(bit_count),
    .write_value(write_value),
    .seek_target(seek_target),
    .done(done),
    .read_value(read_value),
    .error_flag(error_flag),
    .bit_position(bit_position)
  );

  always #10 clk = ~clk;

  function automatic answer_t model_request(input req_t r);
    answer_t              ans;
    int unsigned          n;
    int unsigned          w;
    int unsigned          off;
    logic [WORD_BITS-1:0] m;
    logic [WORD_BITS-1:0] v;
    n = (r.n > CNT_W'(WORD_BITS)) ? WORD_BITS : r.n;
    ans.rd = '0;
    if (r.kind == REQ_WRITE || r.kind == REQ_READ) begin
      if (model_cursor + n > CAPACITY) begin
        model_error = 1'b1;
        n_overruns++;
      end else if (n != 0) begin
        w = model_cursor / WORD_BITS;
        off = model_cursor % WORD_BITS;
        m = (n == WORD_BITS) ? '1 : ((64'd1 << n) - 64'd1);
        if (r.kind == REQ_WRITE) begin
          v = r.value & m;
          model_store[w] |= v << off;
          if (off + n > WORD_BITS) model_store[w+1] |= v >> (WORD_BITS - off);
          model_cursor += n;
          if (model_cursor > model_length) model_length = model_cursor;
        end else begin
          ans.rd = model_store[w] >> off;
          if (off + n > WORD_BITS) ans.rd |= model_store[w+1] << (WORD_BITS - off);
          ans.rd &= m;
          model_cursor += n;
        end
      end
    end else if (r.kind == REQ_SEEK) begin
      model_cursor = (r.target < model_length) ? r.target : model_length;
    end
    ans.err = model_error;
    ans.pos = POS_W'(model_cursor);
    return ans;
  endfunction

  function automatic req_t make_req(input logic [1:0] k, input int unsigned cnt,
                                    input logic [WORD_BITS-1:0] v, input int unsigned t);
    req_t r;
    r.kind = k;
    r.n = CNT_W'(cnt);
    r.value = v;
    r.target = POS_W'(t);
    return r;
  endfunction

  function automatic logic [WORD_BITS-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned rand_count();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 4) return 0;
    else if (sel < 10) return $urandom_range(65, 127);
    else if (sel < 15) return WORD_BITS;
    else if (sel < 20) return 1;
    else return $urandom_range(1, 64);
  endfunction

  task automatic add_row(input logic [1:0] k, input int unsigned cnt,
                         input logic [WORD_BITS-1:0] v, input int unsigned t,
                         input logic typed, input logic [WORD_BITS-1:0] rd,
                         input logic err, input int unsigned pos);
    dir_row_t row;
    row.req = make_req(k, cnt, v, t);
    row.typed = typed;
    row.ans.rd = rd;
    row.ans.err = err;
    row.ans.pos = POS_W'(pos);
    directed_rows.push_back(row);
  endtask

  task automatic transfer_item(input req_t r, input logic typed, input answer_t ans);
    answer_t predicted;
    start <= 1'b1;
    req_type <= r.kind;
    bit_count <= r.n;
    write_value <= r.value;
    seek_target <= r.target;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = model_request(r);
    awaited.push_back(typed ? ans : predicted);
    items_sent++;
    case (r.kind)
      REQ_WRITE: n_writes++;
      REQ_READ:  n_reads++;
      REQ_SEEK:  n_seeks++;
      default:   n_unused++;
    endcase
  endtask

  task automatic pause(input int unsigned cycles);
    start <= 1'b0;
    req_type <= 2'($urandom_range(0, 3));
    bit_count <= CNT_W'($urandom_range(0, 127));
    write_value <= rand_word();
    seek_target <= POS_W'($urandom_range(0, POS_MAX));
    repeat (cycles) @(posedge clk);
  endtask

  task automatic issue(input req_t r);
    answer_t none;
    none = '0;
    transfer_item(r, 1'b0, none);
    if (!tail_phase && items_sent % 50 == 0) idle_enabled = ($urandom_range(0, 2) != 0);
    if (idle_enabled && $urandom_range(0, 4) == 0) pause($urandom_range(1, 7));
  endtask

  task automatic issue_noise();
    logic [1:0]  k;
    int unsigned t;
    k = 2'($urandom_range(0, 3));
    t = $urandom_range(0, 1) ? $urandom_range(0, POS_MAX) : $urandom_range(0, model_length);
    issue(make_req(k, $urandom_range(0, 127), rand_word(), t));
  endtask

  // seek to a random point, write a run of fields, seek back to its start and read the same fields
  task automatic issue_record();
    int unsigned widths [6];
    int unsigned k;
    int unsigned base;
    k = $urandom_range(1, 6);
    if ($urandom_range(0, 1))
      issue(make_req(REQ_SEEK, rand_count(), rand_word(), POS_MAX));
    else
      issue(make_req(REQ_SEEK, rand_count(), rand_word(), $urandom_range(0, model_length)));
    base = model_cursor;
    for (int i = 0; i < k; i++) begin
      widths[i] = rand_count();
      issue(make_req(REQ_WRITE, widths[i], rand_word(), $urandom_range(0, POS_MAX)));
    end
    issue(make_req(REQ_SEEK, rand_count(), rand_word(), base));
    for (int i = 0; i < k; i++)
      issue(make_req(REQ_READ, widths[i], rand_word(), $urandom_range(0, POS_MAX)));
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
      end else begin
        head = awaited.pop_front();
        results_checked++;
        if (read_value !== head.rd) begin
          $error("read_value: expected %h, got %h", head.rd, read_value);
          failures++;
        end
        if (error_flag !== head.err) begin
          $error("error_flag: expected %b, got %b", head.err, error_flag);
          failures++;
        end
        if (bit_position !== head.pos) begin
          $error("bit_position: expected %0d, got %0d", head.pos, bit_position);
          failures++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned drain;
    int unsigned rand_start;
    foreach (model_store[i]) model_store[i] = '0;
    model_cursor = 0;
    model_length = 0;
    model_error = 1'b0;
    idle_enabled = 1'b1;
    tail_phase = 1'b0;

    add_row(REQ_READ,  64, 64'h0, 0, 1'b1, 64'h0, 1'b0, 64);
    add_row(REQ_SEEK,  1, 64'h0, 100, 1'b1, 64'h0, 1'b0, 0);
    add_row(REQ_WRITE, 64, '1, 0, 1'b1, 64'h0, 1'b0, 64);
    add_row(REQ_SEEK,  64, 64'h0, 0, 1'b1, 64'h0, 1'b0, 0);
    add_row(REQ_READ,  64, 64'h0, 0, 1'b1, '1, 1'b0, 64);
    add_row(REQ_WRITE, 0, '1, 0, 1'b1, 64'h0, 1'b0, 64);
    add_row(REQ_READ,  0, 64'h0, 0, 1'b1, 64'h0, 1'b0, 64);
    add_row(REQ_WRITE, 1, 64'h1, 0, 1'b1, 64'h0, 1'b0, 65);
    add_row(REQ_WRITE, 127, 64'hA5A5_A5A5_A5A5_A5A5, 0, 1'b1, 64'h0, 1'b0, 129);
    add_row(REQ_SEEK,  0, 64'h0, POS_MAX, 1'b1, 64'h0, 1'b0, 129);
    add_row(REQ_SEEK,  0, 64'h0, 60, 1'b1, 64'h0, 1'b0, 60);
    add_row(REQ_READ,  10, 64'h0, 0, 1'b0, 64'h0, 1'b0, 0);
    add_row(REQ_NONE,  64, '1, 0, 1'b1, 64'h0, 1'b0, 70);
    add_row(REQ_WRITE, 7, 64'hFFFF_FFFF_FFFF_FF80, 0, 1'b0, 64'h0, 1'b0, 0);
    add_row(REQ_SEEK,  0, 64'h0, CAPACITY, 1'b1, 64'h0, 1'b0, 129);
    add_row(REQ_READ,  65, 64'h0, 0, 1'b0, 64'h0, 1'b0, 0);
    add_row(REQ_SEEK,  0, 64'h0, 0, 1'b1, 64'h0, 1'b0, 0);
    add_row(REQ_READ,  127, 64'h0, 0, 1'b1, '1, 1'b0, 64);
    add_row(REQ_READ,  64, 64'h0, 0, 1'b0, 64'h0, 1'b0, 0);
    add_row(REQ_WRITE, 64, 64'h8000_0000_0000_0001, 0, 1'b0, 64'h0, 1'b0, 0);
    add_row(REQ_SEEK,  0, 64'h0, 127, 1'b0, 64'h0, 1'b0, 0);
    add_row(REQ_READ,  64, 64'h0, 0, 1'b0, 64'h0, 1'b0, 0);
    add_row(REQ_WRITE, 32, 64'hFFFF_FFFF_0000_0000, 0, 1'b0, 64'h0, 1'b0, 0);
    add_row(REQ_SEEK,  0, 64'h0, 180, 1'b0, 64'h0, 1'b0, 0);
    add_row(REQ_READ,  40, 64'h0, 0, 1'b0, 64'h0, 1'b0, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      transfer_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].ans);
      if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 7));
    end

    rand_start = items_sent;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) issue_record();
      else repeat ($urandom_range(1, 3)) issue_noise();
    end

    // finish back to back: seeks past the written end, zero counts, unused codes, then random noise requests
    tail_phase = 1'b1;
    idle_enabled = 1'b0;
    issue(make_req(REQ_SEEK, 64, rand_word(), POS_MAX));
    issue(make_req(REQ_WRITE, 1, '1, 0));
    issue(make_req(REQ_READ, 127, '1, 0));
    issue(make_req(REQ_SEEK, 1, '1, CAPACITY));
    issue(make_req(REQ_READ, 1, '1, 0));
    issue(make_req(REQ_WRITE, 0, '1, 0));
    issue(make_req(REQ_SEEK, 1, '1, 65000));
    issue(make_req(REQ_READ, 64, '1, 0));
    issue(make_req(REQ_WRITE, 64, rand_word(), 0));
    issue(make_req(REQ_SEEK, 1, '1, POS_MAX));
    issue(make_req(REQ_NONE, 64, '1, 0));
    issue(make_req(REQ_SEEK, 1, '1, CAPACITY - 64));
    issue(make_req(REQ_READ, 64, '1, 0));
    repeat (20) issue_noise();

    start <= 1'b0;
    drain = 0;
    while (awaited.size() != 0 && drain < 200) begin
      @(posedge clk);
      drain++;
    end
    if (awaited.size() != 0) begin
      $error("%0d results never arrived", awaited.size());
      failures++;
    end
    repeat (10) @(posedge clk);
    $display("%0d transfers (%0d writes, %0d reads, %0d seeks, %0d unused), %0d overruns",
             items_sent, n_writes, n_reads, n_seeks, n_unused, n_overruns);
    $display("%0d results checked, store filled to %0d bits, %0d failures",
             results_checked, model_length, failures);
    if (failures == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
